// File: rtl/ulb_pkg.sv
// ----------------------------------------------------------------------------
// ulb_pkg
// shared constants, codes and types of the utf-8 line edit buffer
// ----------------------------------------------------------------------------
package ulb_pkg;

  // storage and field sizes
  localparam int unsigned BufBytes = 1024;
  localparam int unsigned PosW     = $clog2(BufBytes);
  localparam int unsigned FuncW    = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 3;

  // utf-8 continuation byte pattern 10xxxxxx
  localparam logic [ByteW-1:0] ContMask = 8'hC0;
  localparam logic [ByteW-1:0] ContMark = 8'h80;

  // result status codes
  localparam logic StatusDone    = 1'b0;
  localparam logic StatusIgnored = 1'b1;

  typedef enum logic [FuncW-1:0] {
    FuncInsert = 4'd0,
    FuncBksp   = 4'd1,
    FuncDelete = 4'd2,
    FuncHome   = 4'd3,
    FuncEnd    = 4'd4,
    FuncLeft   = 4'd5,
    FuncRight  = 4'd6,
    FuncClear  = 4'd7,
    FuncRead   = 4'd8
  } func_e;

  // shift control of one cell row
  // push: every cell takes its lower neighbor, cell 0 takes the new byte
  // pop:  every cell takes its upper neighbor, the last cell wraps to cell 0
  typedef struct packed {
    logic en;
    logic push;
  } shift_t;

  function automatic logic is_cont(input logic [ByteW-1:0] b);
    is_cont = ((b & ContMask) == ContMark);
  endfunction

endpackage

// File: rtl/ulb_if.sv
// ----------------------------------------------------------------------------
// ulb command and result channels
// valid/ready channels that carry edit commands in and results out
// ----------------------------------------------------------------------------
interface ulb_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [ulb_pkg::FuncW-1:0]       func;
  logic [ulb_pkg::ByteW-1:0]       byte_a;
  logic [ulb_pkg::ByteW-1:0]       byte_b;
  logic [ulb_pkg::ByteW-1:0]       byte_c;
  logic [ulb_pkg::ByteW-1:0]       byte_d;
  logic [ulb_pkg::CountW-1:0]      byte_count;
  logic [ulb_pkg::PosW-1:0]        read_index;

  modport source (
    output valid, func, byte_a, byte_b, byte_c, byte_d, byte_count, read_index,
    input  ready
  );
  modport sink (
    input  valid, func, byte_a, byte_b, byte_c, byte_d, byte_count, read_index,
    output ready
  );
endinterface

interface ulb_res_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [ulb_pkg::PosW-1:0]   cursor_pos;
  logic [ulb_pkg::PosW-1:0]   text_length;
  logic [ulb_pkg::ByteW-1:0]  read_data;

  modport source (
    output valid, status, cursor_pos, text_length, read_data,
    input  ready
  );
  modport sink (
    input  valid, status, cursor_pos, text_length, read_data,
    output ready
  );
endinterface

// File: rtl/ulb_cell.sv
// ----------------------------------------------------------------------------
// ulb_cell
// one byte of a cell row, loads from either neighbor on a shift
// ----------------------------------------------------------------------------
module ulb_cell (
  input  logic                      clk_i,
  input  ulb_pkg::shift_t           shift_i,
  input  logic [ulb_pkg::ByteW-1:0] prev_i,
  input  logic [ulb_pkg::ByteW-1:0] next_i,
  output logic [ulb_pkg::ByteW-1:0] data_o
);
  import ulb_pkg::*;

  logic [ByteW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i.en) begin
      data_q <= shift_i.push ? prev_i : next_i;
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/ulb_stack.sv
// ----------------------------------------------------------------------------
// ulb_stack
// row of byte cells used as a stack; cell 0 is the top
// ----------------------------------------------------------------------------
module ulb_stack (
  input  logic                      clk_i,
  input  ulb_pkg::shift_t           shift_i,
  input  logic [ulb_pkg::ByteW-1:0] push_data_i,
  output logic [ulb_pkg::ByteW-1:0] top_o
);
  import ulb_pkg::*;

  logic [ByteW-1:0] cell_data [BufBytes];

  for (genvar i = 0; i < BufBytes; i++) begin : g_cell
    logic [ByteW-1:0] prev_data;
    logic [ByteW-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = push_data_i;
    end else begin : g_inner_prev
      assign prev_data = cell_data[i-1];
    end

    // last cell wraps to the top so a full pass of pops is a rotation
    if (i == BufBytes - 1) begin : g_last
      assign next_data = cell_data[0];
    end else begin : g_inner_next
      assign next_data = cell_data[i+1];
    end

    ulb_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .data_o  (cell_data[i])
    );
  end

  assign top_o = cell_data[0];

endmodule

// File: rtl/utf8_line_edit_buffer.sv
// ----------------------------------------------------------------------------
// utf8_line_edit_buffer
// utf-8 text line with insertion cursor, edited one command item at a time
// ----------------------------------------------------------------------------
// The text is held as two rows of byte cells that act as stacks around the
// cursor: the left row holds the bytes before the cursor with the byte at
// cursor-1 in its first cell, the right row holds the bytes from the cursor
// on with the byte at the cursor in its first cell. Every edit is a series of
// whole-row shifts, one byte per cycle, so the cursor always sits between the
// two first cells. One command is worked at a time; an item is accepted, runs
// its work steps and is then loaded into the result register, where it waits
// while an earlier result is still held. Insert pushes byte_count bytes,
// backspace removes and left moves each byte of the character before the
// cursor, delete removes and right moves each byte of the character at the
// cursor and then find its end, home and end move each byte up to the new
// cursor, and clear, ignored commands and left or right moves that stay put
// take no work steps. A character is a byte with the run of continuation
// bytes that follows it, so in malformed text it can be longer than 4 bytes.
// A read rotates the chosen row once through all BufBytes cells and picks
// the byte on the way. The next command is accepted while a finished result
// still waits in the result register. Text holds at most BufBytes-2 bytes;
// bytes past the length are stale and are never returned.
// ----------------------------------------------------------------------------
module utf8_line_edit_buffer (
  input  logic clk_i,
  input  logic rst_ni,
  ulb_cmd_if.sink   cmd_i,
  ulb_res_if.source res_o
);
  import ulb_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StInsert,
    StBksp,
    StDelete,
    StDeleteMore,
    StLeft,
    StRight,
    StRightMore,
    StHome,
    StEnd,
    StRead,
    StFinish
  } state_e;

  localparam logic [PosW:0]   MaxFill   = (PosW+1)'(BufBytes - 1);
  localparam logic [PosW-1:0] LastCount = PosW'(BufBytes - 1);
  localparam logic [PosW-1:0] PosOne    = PosW'(1);

  state_e            state_q;
  logic [PosW-1:0]   cur_q;       // cursor
  logic [PosW-1:0]   len_q;       // text length
  logic [PosW-1:0]   cnt_q;       // step counter
  logic [PosW-1:0]   pick_q;      // rotation step that holds the read byte
  logic              pick_right_q;
  logic [ByteW-1:0]  ins_q [4];
  logic [CountW-1:0] ins_cnt_q;
  logic              status_q;
  logic [ByteW-1:0]  rdata_q;

  // result register
  logic              res_valid_q;
  logic              res_status_q;
  logic [PosW-1:0]   res_cursor_q;
  logic [PosW-1:0]   res_length_q;
  logic [ByteW-1:0]  res_rdata_q;

  // row control
  shift_t            left_shift;
  shift_t            right_shift;
  logic [ByteW-1:0]  left_push;
  logic [ByteW-1:0]  right_push;
  logic [ByteW-1:0]  left_top;
  logic [ByteW-1:0]  right_top;

  logic              accept;
  logic              res_free;
  logic [PosW:0]     fill_sum;
  logic              ins_last;
  logic              more_right;   // another continuation byte right of cursor

  assign accept     = cmd_i.valid && cmd_i.ready;
  assign res_free   = !res_valid_q || res_o.ready;
  assign fill_sum   = {1'b0, len_q} + (PosW+1)'(cmd_i.byte_count);
  assign ins_last   = ({1'b0, cnt_q[1:0]} + CountW'(1)) == ins_cnt_q;
  assign more_right = (cur_q < len_q) && is_cont(right_top);

  // ---------------------------------------------------------------------
  // row shift control
  // ---------------------------------------------------------------------
  always_comb begin
    left_shift  = '0;
    right_shift = '0;
    left_push   = right_top;
    right_push  = left_top;
    case (state_q)
      StInsert: begin
        // push the next character byte onto the left row
        left_shift = '{en: 1'b1, push: 1'b1};
        left_push  = ins_q[cnt_q[1:0]];
      end
      StBksp: begin
        left_shift = '{en: 1'b1, push: 1'b0};
      end
      StLeft: begin
        // byte before the cursor moves over to the right row
        left_shift  = '{en: 1'b1, push: 1'b0};
        right_shift = '{en: 1'b1, push: 1'b1};
      end
      StHome: begin
        if (cur_q != '0) begin
          left_shift  = '{en: 1'b1, push: 1'b0};
          right_shift = '{en: 1'b1, push: 1'b1};
        end
      end
      StDelete: begin
        right_shift = '{en: 1'b1, push: 1'b0};
      end
      StDeleteMore: begin
        if (more_right) begin
          right_shift = '{en: 1'b1, push: 1'b0};
        end
      end
      StRight: begin
        right_shift = '{en: 1'b1, push: 1'b0};
        left_shift  = '{en: 1'b1, push: 1'b1};
      end
      StRightMore: begin
        if (more_right) begin
          right_shift = '{en: 1'b1, push: 1'b0};
          left_shift  = '{en: 1'b1, push: 1'b1};
        end
      end
      StEnd: begin
        if (cur_q != len_q) begin
          right_shift = '{en: 1'b1, push: 1'b0};
          left_shift  = '{en: 1'b1, push: 1'b1};
        end
      end
      StRead: begin
        // full rotation of one row through all its cells, which restores it
        if (pick_right_q) begin
          right_shift = '{en: 1'b1, push: 1'b0};
        end else begin
          left_shift  = '{en: 1'b1, push: 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  ulb_stack u_left (
    .clk_i       (clk_i),
    .shift_i     (left_shift),
    .push_data_i (left_push),
    .top_o       (left_top)
  );

  ulb_stack u_right (
    .clk_i       (clk_i),
    .shift_i     (right_shift),
    .push_data_i (right_push),
    .top_o       (right_top)
  );

  // ---------------------------------------------------------------------
  // command sequencer and result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cur_q        <= '0;
      len_q        <= '0;
      cnt_q        <= '0;
      pick_q       <= '0;
      pick_right_q <= 1'b0;
      ins_cnt_q    <= '0;
      status_q     <= StatusDone;
      rdata_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            status_q <= StatusDone;
            rdata_q  <= '0;
            cnt_q    <= '0;
            state_q  <= StFinish;
            case (func_e'(cmd_i.func))
              FuncInsert: begin
                if (cmd_i.byte_count == '0 || cmd_i.byte_count > CountW'(4) ||
                    fill_sum >= MaxFill) begin
                  status_q <= StatusIgnored;
                end else begin
                  ins_q[0]  <= cmd_i.byte_a;
                  ins_q[1]  <= cmd_i.byte_b;
                  ins_q[2]  <= cmd_i.byte_c;
                  ins_q[3]  <= cmd_i.byte_d;
                  ins_cnt_q <= cmd_i.byte_count;
                  state_q   <= StInsert;
                end
              end
              FuncBksp: begin
                if (cur_q == '0) begin
                  status_q <= StatusIgnored;
                end else begin
                  state_q <= StBksp;
                end
              end
              FuncDelete: begin
                if (cur_q >= len_q) begin
                  status_q <= StatusIgnored;
                end else begin
                  state_q <= StDelete;
                end
              end
              FuncHome: state_q <= StHome;
              FuncEnd:  state_q <= StEnd;
              FuncLeft: begin
                if (cur_q != '0) begin
                  state_q <= StLeft;
                end
              end
              FuncRight: begin
                if (cur_q < len_q) begin
                  state_q <= StRight;
                end
              end
              FuncClear: begin
                cur_q <= '0;
                len_q <= '0;
              end
              FuncRead: begin
                if (cmd_i.read_index >= len_q) begin
                  status_q <= StatusIgnored;
                end else if (cmd_i.read_index < cur_q) begin
                  // byte sits in the left row, counted down from the cursor
                  pick_right_q <= 1'b0;
                  pick_q       <= cur_q - cmd_i.read_index - PosOne;
                  state_q      <= StRead;
                end else begin
                  pick_right_q <= 1'b1;
                  pick_q       <= cmd_i.read_index - cur_q;
                  state_q      <= StRead;
                end
              end
              default: status_q <= StatusIgnored;
            endcase
          end
        end
        StInsert: begin
          cur_q <= cur_q + PosOne;
          len_q <= len_q + PosOne;
          cnt_q <= cnt_q + PosOne;
          if (ins_last) begin
            state_q <= StFinish;
          end
        end
        StBksp: begin
          // keep removing while the removed byte continues a character
          cur_q <= cur_q - PosOne;
          len_q <= len_q - PosOne;
          if (!(is_cont(left_top) && cur_q != PosOne)) begin
            state_q <= StFinish;
          end
        end
        StLeft: begin
          cur_q <= cur_q - PosOne;
          if (!(is_cont(left_top) && cur_q != PosOne)) begin
            state_q <= StFinish;
          end
        end
        StDelete: begin
          len_q   <= len_q - PosOne;
          state_q <= StDeleteMore;
        end
        StDeleteMore: begin
          if (more_right) begin
            len_q <= len_q - PosOne;
          end else begin
            state_q <= StFinish;
          end
        end
        StRight: begin
          cur_q   <= cur_q + PosOne;
          state_q <= StRightMore;
        end
        StRightMore: begin
          if (more_right) begin
            cur_q <= cur_q + PosOne;
          end else begin
            state_q <= StFinish;
          end
        end
        StHome: begin
          if (cur_q != '0) begin
            cur_q <= cur_q - PosOne;
          end else begin
            state_q <= StFinish;
          end
        end
        StEnd: begin
          if (cur_q != len_q) begin
            cur_q <= cur_q + PosOne;
          end else begin
            state_q <= StFinish;
          end
        end
        StRead: begin
          if (cnt_q == pick_q) begin
            rdata_q <= pick_right_q ? right_top : left_top;
          end
          cnt_q <= cnt_q + PosOne;
          if (cnt_q == LastCount) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (res_free) begin
            res_valid_q  <= 1'b1;
            res_status_q <= status_q;
            res_cursor_q <= cur_q;
            res_length_q <= len_q;
            res_rdata_q  <= rdata_q;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign cmd_i.ready       = (state_q == StIdle);
  assign res_o.valid       = res_valid_q;
  assign res_o.status      = res_status_q;
  assign res_o.cursor_pos  = res_cursor_q;
  assign res_o.text_length = res_length_q;
  assign res_o.read_data   = res_rdata_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // text never grows past the two spare bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= PosW'(BufBytes - 2))
    else $error("text length beyond capacity");

  // cursor stays inside the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor past text length");

  // an accepted item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != StIdle)
    else $error("accepted item did not start work");

  // a result only appears out of the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q) == StFinish)
    else $error("result loaded outside finish step");

  // rows shift only while a command is at work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_shift.en || right_shift.en) |-> (state_q != StIdle && state_q != StFinish))
    else $error("row shifted while idle");

endmodule

// File: tb/ulb_edit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulb_edit_checker
// watches the command and result channels of the line edit buffer, keeps its
// own copy of the text, cursor and length, and compares every result with the
// one predicted for the oldest outstanding command
// ----------------------------------------------------------------------------
module ulb_edit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ulb_cmd_if          cmd_i,
  ulb_res_if          res_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import ulb_pkg::*;

  localparam int unsigned MaxCharBytes = 4;
  localparam int unsigned MaxReports   = 10;

  typedef struct packed {
    logic             status;
    logic [PosW-1:0]  cursor_pos;
    logic [PosW-1:0]  text_length;
    logic [ByteW-1:0] read_data;
  } edit_result_t;

  logic [ByteW-1:0] text_bytes [BufBytes];
  int unsigned      cursor_at;
  int unsigned      text_len;
  edit_result_t     result_q [$];
  int unsigned      mismatches;

  function automatic bit is_trail(input int unsigned pos);
    return (text_bytes[pos] & ContMask) == ContMark;
  endfunction

  // first byte of the character that ends just below pos
  function automatic int unsigned prev_char_start(input int unsigned pos);
    int unsigned p;
    if (pos == 0) return 0;
    p = pos - 1;
    while (p > 0 && is_trail(p)) p--;
    return p;
  endfunction

  // one past the last byte of the character that starts at pos
  function automatic int unsigned next_char_end(input int unsigned pos);
    int unsigned p;
    if (pos >= text_len) return text_len;
    p = pos + 1;
    while (p < text_len && is_trail(p)) p++;
    return p;
  endfunction

  function automatic edit_result_t apply_edit(
    input logic [FuncW-1:0]  func,
    input logic [ByteW-1:0]  b0, b1, b2, b3,
    input logic [CountW-1:0] count,
    input logic [PosW-1:0]   ridx
  );
    edit_result_t     r;
    logic [ByteW-1:0] lanes [MaxCharBytes];
    int unsigned      n;
    int unsigned      edge_pos;
    int               i;
    r = '0;
    r.status = StatusDone;
    lanes[0] = b0;
    lanes[1] = b1;
    lanes[2] = b2;
    lanes[3] = b3;
    case (func)
      FuncInsert: begin
        if (count == 0 || count > MaxCharBytes || text_len + count >= BufBytes - 1) begin
          r.status = StatusIgnored;
        end else begin
          for (i = int'(text_len) - 1; i >= int'(cursor_at); i--)
            text_bytes[i + count] = text_bytes[i];
          for (i = 0; i < int'(count); i++)
            text_bytes[cursor_at + i] = lanes[i];
          text_len  += count;
          cursor_at += count;
        end
      end
      FuncBksp: begin
        if (cursor_at == 0) begin
          r.status = StatusIgnored;
        end else begin
          edge_pos = prev_char_start(cursor_at);
          n = cursor_at - edge_pos;
          for (i = int'(cursor_at); i < int'(text_len); i++)
            text_bytes[i - n] = text_bytes[i];
          text_len -= n;
          cursor_at = edge_pos;
        end
      end
      FuncDelete: begin
        if (cursor_at >= text_len) begin
          r.status = StatusIgnored;
        end else begin
          edge_pos = next_char_end(cursor_at);
          n = edge_pos - cursor_at;
          for (i = int'(edge_pos); i < int'(text_len); i++)
            text_bytes[i - n] = text_bytes[i];
          text_len -= n;
        end
      end
      FuncHome:  cursor_at = 0;
      FuncEnd:   cursor_at = text_len;
      FuncLeft:  cursor_at = prev_char_start(cursor_at);
      FuncRight: cursor_at = next_char_end(cursor_at);
      FuncClear: begin
        text_len  = 0;
        cursor_at = 0;
      end
      FuncRead: begin
        if (ridx >= text_len) r.status = StatusIgnored;
        else r.read_data = text_bytes[ridx];
      end
      default: r.status = StatusIgnored;
    endcase
    r.cursor_pos  = PosW'(cursor_at);
    r.text_length = PosW'(text_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    edit_result_t want;
    edit_result_t got;
    if (!rst_ni) begin
      cursor_at = 0;
      text_len  = 0;
      result_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.status      = res_i.status;
        got.cursor_pos  = res_i.cursor_pos;
        got.text_length = res_i.text_length;
        got.read_data   = res_i.read_data;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("[%0t] result with no command outstanding: status %0d cursor %0d length %0d data %02h",
                     $time, got.status, got.cursor_pos, got.text_length, got.read_data);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("[%0t] mismatch (exp/act): status %0d/%0d cursor %0d/%0d length %0d/%0d data %02h/%02h",
                       $time, want.status, got.status, want.cursor_pos, got.cursor_pos,
                       want.text_length, got.text_length, want.read_data, got.read_data);
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        result_q.push_back(apply_edit(cmd_i.func, cmd_i.byte_a, cmd_i.byte_b, cmd_i.byte_c,
                                      cmd_i.byte_d, cmd_i.byte_count, cmd_i.read_index));
      mismatch_count_o <= mismatches;
      pending_o        <= result_q.size();
    end
  end

endmodule

// File: tb/utf8_line_edit_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_line_edit_buffer_test
// drives edit commands into the line edit buffer under several idling
// patterns: a directed pass over the corner cases, a mixed random pass, a fill
// of the whole buffer to hit the full limit, and random passes on a full and
// on an emptied text; results are judged by the checker beside the block
// ----------------------------------------------------------------------------
module utf8_line_edit_buffer_test;
  import ulb_pkg::*;

  // run limits: a read walks the whole store, so a read is the slowest item;
  // the limit covers every item being as slow as a read
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = BufBytes + 16;

  // utf-8 lead byte ranges for well-formed characters
  localparam logic [ByteW-1:0] AsciiHi = 8'h7F;
  localparam logic [ByteW-1:0] Lead2Lo = 8'hC2;
  localparam logic [ByteW-1:0] Lead2Hi = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Lo = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Hi = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Lo = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Hi = 8'hF4;

  // command codes outside the defined set
  localparam logic [FuncW-1:0] FuncUnusedLo = 4'd9;
  localparam logic [FuncW-1:0] FuncUnusedHi = 4'd15;

  typedef enum {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned cycle_count = 0;
  int unsigned mismatches;
  int unsigned pending;

  ulb_cmd_if cmd_ch ();
  ulb_res_if res_ch ();

  utf8_line_edit_buffer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  ulb_edit_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_ch),
    .res_i            (res_ch),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop if the block hangs or a result never shows up
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: ready drops at random with the current stall rate
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // gap rate is only read by the stimulus process; the stall rate goes
  // through a nonblocking update since the receiver process reads it
  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IdleNone: begin
        gap_pct = 0;
        stall_pct <= 0;
      end
      IdleSender: begin
        gap_pct = 70;
        stall_pct <= 0;
      end
      IdleReceiver: begin
        gap_pct = 0;
        stall_pct <= 70;
      end
      default: begin
        gap_pct = 11;
        stall_pct <= 11;
      end
    endcase
  endtask

  // one command item: optional idle cycles, then hold valid until accepted;
  // valid is left high so back-to-back items keep it up without a dip
  task automatic send_edit(
    input logic [FuncW-1:0]  func,
    input logic [ByteW-1:0]  b0, b1, b2, b3,
    input logic [CountW-1:0] count,
    input logic [PosW-1:0]   ridx
  );
    while ($urandom_range(0, 99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.func       <= func;
    cmd_ch.byte_a     <= b0;
    cmd_ch.byte_b     <= b1;
    cmd_ch.byte_c     <= b2;
    cmd_ch.byte_d     <= b3;
    cmd_ch.byte_count <= count;
    cmd_ch.read_index <= ridx;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  // non-insert command with random filler in the unused fields
  task automatic send_op(input logic [FuncW-1:0] func, input logic [PosW-1:0] ridx);
    send_edit(func, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
              CountW'($urandom), ridx);
  endtask

  // insert one character of nbytes bytes; a garbled one carries random bytes,
  // so stray continuation bytes and broken leads get into the text
  task automatic insert_char(input int unsigned nbytes, input bit garbled);
    logic [ByteW-1:0] lane [4];
    int               i;
    for (i = 0; i < 4; i++) lane[i] = ByteW'($urandom);
    if (!garbled) begin
      for (i = 1; i < int'(nbytes); i++) lane[i] = ContMark | ByteW'($urandom_range(0, 63));
      case (nbytes)
        1:       lane[0] = ByteW'($urandom_range(0, AsciiHi));
        2:       lane[0] = ByteW'($urandom_range(Lead2Lo, Lead2Hi));
        3:       lane[0] = ByteW'($urandom_range(Lead3Lo, Lead3Hi));
        default: lane[0] = ByteW'($urandom_range(Lead4Lo, Lead4Hi));
      endcase
    end
    send_edit(FuncInsert, lane[0], lane[1], lane[2], lane[3], CountW'(nbytes),
              PosW'($urandom));
  endtask

  // mixed random edit, weighted toward inserts so the text keeps some body
  task automatic random_edit();
    int unsigned      pick;
    logic [PosW-1:0]  ridx;
    pick = $urandom_range(0, 99);
    // reads favor low positions so that most land inside the text
    ridx = $urandom_range(0, 1) ? PosW'($urandom_range(0, 63))
                                : PosW'($urandom_range(0, BufBytes - 1));
    if (pick < 40)      insert_char($urandom_range(1, 4), $urandom_range(0, 99) < 15);
    else if (pick < 50) send_op(FuncBksp, ridx);
    else if (pick < 60) send_op(FuncDelete, ridx);
    else if (pick < 65) send_op(FuncHome, ridx);
    else if (pick < 70) send_op(FuncEnd, ridx);
    else if (pick < 80) send_op(FuncLeft, ridx);
    else if (pick < 90) send_op(FuncRight, ridx);
    else if (pick < 92) send_op(FuncClear, ridx);
    else                send_op(FuncRead, ridx);
  endtask

  initial begin : stimulus
    int k;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.func       <= FuncHome;
    cmd_ch.byte_a     <= '0;
    cmd_ch.byte_b     <= '0;
    cmd_ch.byte_c     <= '0;
    cmd_ch.byte_d     <= '0;
    cmd_ch.byte_count <= '0;
    cmd_ch.read_index <= '0;
    rst_ni            <= 1'b0;
    set_idling(IdleNone);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed corner cases, no idling ----
    // empty text: read, backspace and delete are ignored, moves stay put
    send_op(FuncRead, '0);
    send_op(FuncBksp, '0);
    send_op(FuncDelete, '0);
    send_op(FuncLeft, '0);
    send_op(FuncRight, '0);
    // one character of each length, zero byte and all-ones filler lanes
    send_edit(FuncInsert, 8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1, '1);
    send_edit(FuncInsert, 8'hF0, 8'h9F, 8'h98, 8'h80, 3'd4, '0);
    send_edit(FuncInsert, 8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2, '1);
    send_edit(FuncInsert, 8'hE2, 8'h82, 8'hAC, 8'hFF, 3'd3, '0);
    // counts outside one to four are refused
    send_edit(FuncInsert, 8'h41, 8'h42, 8'h43, 8'h44, 3'd0, '0);
    send_edit(FuncInsert, 8'h41, 8'h42, 8'h43, 8'h44, 3'd7, '0);
    // bad lead byte followed by a stray continuation byte
    send_edit(FuncInsert, 8'hFF, 8'h00, 8'h00, 8'h00, 3'd1, '0);
    send_edit(FuncInsert, 8'h80, 8'h00, 8'h00, 8'h00, 3'd1, '0);
    // walk the text by whole characters and cut some out
    send_op(FuncHome, '0);
    send_op(FuncRight, '0);
    send_op(FuncRight, '0);
    send_op(FuncDelete, '0);
    send_op(FuncEnd, '0);
    send_op(FuncLeft, '0);
    send_op(FuncBksp, '0);
    // read past the end, read inside, then codes with no meaning
    send_op(FuncRead, '1);
    send_op(FuncRead, PosW'(1));
    send_op(FuncUnusedLo, '0);
    send_op(FuncUnusedHi, '1);
    send_op(FuncClear, '0);

    repeat (70) random_edit();

    // ---- fill the whole buffer with four-byte characters ----
    set_idling(IdleSender);
    send_op(FuncClear, '0);
    for (k = 0; k < (BufBytes - 4) / 4; k++) begin
      // now and then move the cursor so the insert lands mid-text
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 2))
          0:       send_op(FuncHome, '0);
          1:       send_op(FuncLeft, '0);
          default: send_op(FuncRight, '0);
        endcase
      end
      insert_char(4, 1'b0);
    end
    // two single bytes top it off, after that every insert is refused
    insert_char(1, 1'b0);
    insert_char(1, 1'b0);
    insert_char(1, 1'b0);
    insert_char(4, 1'b0);
    send_op(FuncRead, PosW'(BufBytes - 3));
    send_op(FuncRead, PosW'(BufBytes - 2));
    send_op(FuncRead, PosW'(BufBytes - 1));
    send_op(FuncHome, '0);
    send_op(FuncBksp, '0);
    send_op(FuncEnd, '0);
    send_op(FuncDelete, '0);
    send_op(FuncLeft, '0);
    insert_char(2, 1'b0);

    // ---- random edits on the full text, receiver stalling ----
    set_idling(IdleReceiver);
    repeat (140) random_edit();

    // ---- random edits from an empty text, both sides idling ----
    set_idling(IdleBoth);
    send_op(FuncClear, '0);
    repeat (80) random_edit();

    cmd_ch.valid <= 1'b0;
    // let the checker count the last item before pending is read
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ulb_pkg.sv
rtl/ulb_if.sv
rtl/ulb_cell.sv
rtl/ulb_stack.sv
rtl/utf8_line_edit_buffer.sv
tb/ulb_edit_checker.sv
tb/utf8_line_edit_buffer_test.sv
